[design/mstg_pkg.sv]
// Shared types, codes and constants of the melody sequencer tone generator.
// No dependencies; every other design file but mstg_if imports this package.
`default_nettype none

package mstg_pkg;

   // Request kinds carried in the req_type field
   typedef enum logic [1:0] {
      REQ_TICK        = 2'd0,
      REQ_TOGGLE_PLAY = 2'd1,
      REQ_NEXT_SONG   = 2'd2,
      REQ_WRITE_ENTRY = 2'd3
   } req_kind_type;

   // Playback phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ENTRY = 2'd1,
      PH_GAP   = 2'd2
   } phase_type;

   // Control register indexes and reset values
   localparam logic [7:0]  CSR_DELAY_UNIT_TICKS   = 8'd0;
   localparam logic [7:0]  CSR_GAP_UNITS          = 8'd1;
   localparam logic [25:0] DELAY_UNIT_TICKS_RESET = 26'd4000000;
   localparam logic [7:0]  GAP_UNITS_RESET        = 8'd40;

   // Note codes
   localparam logic [7:0] CODE_SHORT_PAUSE = 8'd254;
   localparam logic [7:0] CODE_LAST_TONE   = 8'd20;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] song_number;
      logic [7:0] entry_index;
      logic [7:0] note_code;
      logic [7:0] hold_units;
   } req_payload_type;

   typedef struct packed {
      logic       speaker_level;
      logic       playing;
      logic [1:0] current_song;
      logic [7:0] current_entry;
   } rsp_payload_type;

   typedef struct packed {
      logic [25:0] delay_unit_ticks;
      logic [7:0]  gap_units;
   } cfg_type;

   // Read side of the song store: song and position of the next state
   typedef struct packed {
      logic [1:0] song;
      logic [7:0] pos;
   } store_rd_type;

   // Write side of the song store; entry word is {hold, code}
   typedef struct packed {
      logic        en;
      logic [1:0]  song;
      logic [7:0]  entry;
      logic [15:0] data;
   } store_wr_type;

   // Prefetched entries: entry 0 of the song and the entry after pos
   typedef struct packed {
      logic [15:0] first_entry;
      logic [15:0] next_entry;
   } store_data_type;

   // Half period of each tone, in ticks minus one
   function automatic logic [14:0] tone_half_period_of(input logic [4:0] idx);
      logic [14:0] val;
      case (idx)
         5'd0:    val = 15'd30534;
         5'd1:    val = 15'd27211;
         5'd2:    val = 15'd24242;
         5'd3:    val = 15'd22923;
         5'd4:    val = 15'd20408;
         5'd5:    val = 15'd18182;
         5'd6:    val = 15'd16194;
         5'd7:    val = 15'd15289;
         5'd8:    val = 15'd13621;
         5'd9:    val = 15'd12135;
         5'd10:   val = 15'd11454;
         5'd11:   val = 15'd10204;
         5'd12:   val = 15'd9091;
         5'd13:   val = 15'd8099;
         5'd14:   val = 15'd7645;
         5'd15:   val = 15'd6810;
         5'd16:   val = 15'd6067;
         5'd17:   val = 15'd5727;
         5'd18:   val = 15'd5102;
         5'd19:   val = 15'd4545;
         5'd20:   val = 15'd4050;
         default: val = 15'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[design/mstg_if.sv]
// Valid/ready channel interfaces of the melody sequencer tone generator:
// request, response and control register write. No dependencies.
`default_nettype none

interface mstg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [1:0] song_number;
   logic [7:0] entry_index;
   logic [7:0] note_code;
   logic [7:0] hold_units;

   modport source (output valid, req_type, song_number, entry_index, note_code,
                   hold_units, input ready);
   modport sink (input valid, req_type, song_number, entry_index, note_code,
                 hold_units, output ready);
endinterface

interface mstg_rsp_if;
   logic       valid;
   logic       ready;
   logic       speaker_level;
   logic       playing;
   logic [1:0] current_song;
   logic [7:0] current_entry;

   modport source (output valid, speaker_level, playing, current_song, current_entry,
                   input ready);
   modport sink (input valid, speaker_level, playing, current_song, current_entry,
                 output ready);
endinterface

interface mstg_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  wr_index;
   logic [25:0] wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

[design/mstg_store.sv]
// Song store: one write port, two registered read ports (entry 0 and the entry
// after the current position), with write forwarding. Depends on mstg_pkg.
`default_nettype none

module mstg_store #(
   parameter int SONG_COUNT       = 3,
   parameter int ENTRIES_PER_SONG = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mstg_pkg::store_wr_type  wr,
   input  mstg_pkg::store_rd_type  rd,
   output mstg_pkg::store_data_type rd_data
);
   import mstg_pkg::*;

   localparam int DEPTH = SONG_COUNT * ENTRIES_PER_SONG;
   localparam int AW    = $clog2(DEPTH);

   logic [15:0]   song_store_mem [DEPTH];
   logic [15:0]   first_rd_ff;
   logic [15:0]   next_rd_ff;
   logic [15:0]   fwd_data_ff;
   logic          fwd_first_ff;
   logic          fwd_next_ff;
   logic          wr_ok;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] first_addr;
   logic [AW-1:0] next_addr;
   logic [8:0]    pos_inc;
   logic [7:0]    next_pos;

   function automatic logic [AW-1:0] addr_of(input logic [1:0] song, input logic [7:0] entry);
      return AW'(song) * AW'(ENTRIES_PER_SONG) + AW'(entry);
   endfunction

   // Address decode; out-of-range writes are dropped
   always_comb begin
      wr_ok = wr.en && ({1'b0, wr.song} < 3'(SONG_COUNT))
                    && ({1'b0, wr.entry} < 9'(ENTRIES_PER_SONG));
      wr_addr    = addr_of(wr.song, wr.entry);
      pos_inc    = {1'b0, rd.pos} + 9'd1;
      next_pos   = (pos_inc >= 9'(ENTRIES_PER_SONG)) ? 8'd0 : pos_inc[7:0];
      first_addr = addr_of(rd.song, 8'd0);
      next_addr  = addr_of(rd.song, next_pos);
   end

   // Memory array: write, and read both prefetch addresses every cycle
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         song_store_mem[wr_addr] <= wr.data;
      end
      first_rd_ff <= song_store_mem[first_addr];
      next_rd_ff  <= song_store_mem[next_addr];
      fwd_data_ff <= wr.data;
   end

   // A write to an address read in the same cycle wins over the old data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_first_ff <= 1'b0;
         fwd_next_ff  <= 1'b0;
      end else begin
         fwd_first_ff <= wr_ok && (wr_addr == first_addr);
         fwd_next_ff  <= wr_ok && (wr_addr == next_addr);
      end
   end

   assign rd_data.first_entry = fwd_first_ff ? fwd_data_ff : first_rd_ff;
   assign rd_data.next_entry  = fwd_next_ff ? fwd_data_ff : next_rd_ff;

endmodule

`default_nettype wire

[design/mstg_engine.sv]
// Playback engine: phase, unit and tone counters, speaker level. Computes the
// next state per request and drives the store prefetch. Depends on mstg_pkg.
`default_nettype none

module mstg_engine #(
   parameter int SONG_COUNT       = 3,
   parameter int ENTRIES_PER_SONG = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  mstg_pkg::req_payload_type req,
   input  mstg_pkg::cfg_type         cfg,
   input  mstg_pkg::store_data_type  store_data,
   output mstg_pkg::store_rd_type    store_rd,
   output mstg_pkg::store_wr_type    store_wr,
   output mstg_pkg::rsp_payload_type result
);
   import mstg_pkg::*;

   typedef struct packed {
      phase_type   ph;
      logic [9:0]  units;
      logic        tone_on;
      logic [14:0] thp;
   } load_type;

   phase_type   phase_ff, phase_in;
   logic        play_ff, play_in;
   logic [1:0]  song_ff, song_in;
   logic [7:0]  pos_ff, pos_in;
   logic [9:0]  units_ff, units_in;
   logic [25:0] utick_ff, utick_in;
   logic [14:0] thp_ff, thp_in;
   logic [14:0] tcount_ff, tcount_in;
   logic        tone_on_ff, tone_on_in;
   logic        spk_ff, spk_in;
   load_type    ld;

   // Decode one song entry into the state it starts
   function automatic load_type load_entry(input logic [15:0] e, input logic [7:0] gap,
                                           input logic [14:0] thp_cur);
      load_type   r;
      logic [7:0] code;
      logic [7:0] hold;
      code      = e[7:0];
      hold      = e[15:8];
      r.thp     = thp_cur;
      r.tone_on = 1'b0;
      if (hold == 8'd0) begin
         r.ph    = PH_GAP;
         r.units = {2'b00, gap};
      end else begin
         r.ph = PH_ENTRY;
         if (code == CODE_SHORT_PAUSE) begin
            r.units = 10'd1;
         end else begin
            r.units = {hold, 2'b00};
            if (code <= CODE_LAST_TONE) begin
               r.tone_on = 1'b1;
               r.thp     = tone_half_period_of(code[4:0]);
            end
         end
      end
      return r;
   endfunction

   // Next state for the accepted request
   always_comb begin
      phase_in   = phase_ff;
      play_in    = play_ff;
      song_in    = song_ff;
      pos_in     = pos_ff;
      units_in   = units_ff;
      utick_in   = utick_ff;
      thp_in     = thp_ff;
      tcount_in  = tcount_ff;
      tone_on_in = tone_on_ff;
      spk_in     = spk_ff;
      ld         = '0;

      if (fire) begin
         case (req_kind_type'(req.req_type))
            REQ_TICK: begin
               if (play_ff) begin
                  // leaving idle: start at entry 0
                  if (phase_ff == PH_IDLE) begin
                     pos_in     = 8'd0;
                     ld         = load_entry(store_data.first_entry, cfg.gap_units, thp_in);
                     phase_in   = ld.ph;
                     units_in   = ld.units;
                     tone_on_in = ld.tone_on;
                     thp_in     = ld.thp;
                     utick_in   = 26'd0;
                     tcount_in  = 15'd0;
                  end
                  // square wave divider
                  if (tone_on_in) begin
                     if (tcount_in >= thp_in) begin
                        spk_in    = ~spk_in;
                        tcount_in = 15'd0;
                     end else begin
                        tcount_in = tcount_in + 15'd1;
                     end
                  end
                  // unit timer
                  if (units_in != 10'd0) begin
                     utick_in = utick_in + 26'd1;
                     if (utick_in >= cfg.delay_unit_ticks) begin
                        utick_in = 26'd0;
                        units_in = units_in - 10'd1;
                     end
                  end
                  // advance to the next entry, the gap, or back to entry 0
                  if (units_in == 10'd0) begin
                     if (phase_in == PH_GAP) begin
                        pos_in     = 8'd0;
                        ld         = load_entry(store_data.first_entry, cfg.gap_units,
                                                thp_in);
                        phase_in   = ld.ph;
                        units_in   = ld.units;
                        tone_on_in = ld.tone_on;
                        thp_in     = ld.thp;
                     end else if (({1'b0, pos_in} + 9'd1) >= 9'(ENTRIES_PER_SONG)) begin
                        phase_in   = PH_GAP;
                        units_in   = {2'b00, cfg.gap_units};
                        tone_on_in = 1'b0;
                     end else begin
                        pos_in     = pos_in + 8'd1;
                        ld         = load_entry(store_data.next_entry, cfg.gap_units,
                                                thp_in);
                        phase_in   = ld.ph;
                        units_in   = ld.units;
                        tone_on_in = ld.tone_on;
                        thp_in     = ld.thp;
                     end
                     utick_in  = 26'd0;
                     tcount_in = 15'd0;
                  end
               end
            end
            REQ_TOGGLE_PLAY, REQ_NEXT_SONG: begin
               if (req.req_type == REQ_TOGGLE_PLAY) begin
                  play_in = ~play_ff;
               end else begin
                  song_in = (({1'b0, song_ff} + 3'd1) >= 3'(SONG_COUNT)) ? 2'd0
                                                                        : song_ff + 2'd1;
               end
               // stop at once
               phase_in   = PH_IDLE;
               pos_in     = 8'd0;
               units_in   = 10'd0;
               utick_in   = 26'd0;
               tcount_in  = 15'd0;
               tone_on_in = 1'b0;
               spk_in     = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Store access: write port straight from the request, reads from next state
   always_comb begin
      store_wr.en    = fire && (req.req_type == REQ_WRITE_ENTRY);
      store_wr.song  = req.song_number;
      store_wr.entry = req.entry_index;
      store_wr.data  = {req.hold_units, req.note_code};
      store_rd.song  = song_in;
      store_rd.pos   = pos_in;
   end

   assign result.speaker_level = spk_in;
   assign result.playing       = play_in;
   assign result.current_song  = song_in;
   assign result.current_entry = pos_in;

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Counters and playback state
   always_ff @(posedge clock) begin
      if (reset) begin
         play_ff    <= 1'b0;
         song_ff    <= 2'd0;
         pos_ff     <= 8'd0;
         units_ff   <= 10'd0;
         utick_ff   <= 26'd0;
         thp_ff     <= 15'd0;
         tcount_ff  <= 15'd0;
         tone_on_ff <= 1'b0;
         spk_ff     <= 1'b0;
      end else begin
         play_ff    <= play_in;
         song_ff    <= song_in;
         pos_ff     <= pos_in;
         units_ff   <= units_in;
         utick_ff   <= utick_in;
         thp_ff     <= thp_in;
         tcount_ff  <= tcount_in;
         tone_on_ff <= tone_on_in;
         spk_ff     <= spk_in;
      end
   end

   // Idle must sit at entry 0 so the next-entry prefetch points at entry 1
   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> pos_ff == 8'd0 && units_ff == 10'd0 && !tone_on_ff)
      else $error("idle phase with live position or counters");

   a_stopped_is_idle: assert property (@(posedge clock) disable iff (reset)
      !play_ff |-> phase_ff == PH_IDLE)
      else $error("playback disabled but phase not idle");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (req.req_type == REQ_TOGGLE_PLAY || req.req_type == REQ_NEXT_SONG)
      |=> phase_ff == PH_IDLE && !spk_ff && utick_ff == 26'd0)
      else $error("stop did not clear playback state");

   a_tone_count_bound: assert property (@(posedge clock) disable iff (reset)
      tone_on_ff |-> tcount_ff <= thp_ff)
      else $error("tone counter past half period");

   a_write_keeps_state: assert property (@(posedge clock) disable iff (reset)
      fire && req.req_type == REQ_WRITE_ENTRY
      |=> pos_ff == $past(pos_ff) && phase_ff == $past(phase_ff) && spk_ff == $past(spk_ff))
      else $error("entry write disturbed playback");

endmodule

`default_nettype wire

[design/mstg_rsp_buf.sv]
// Two-entry response buffer between the engine and the response channel, so
// a request is taken while one response waits. Depends on mstg_pkg.
`default_nettype none

module mstg_rsp_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mstg_pkg::rsp_payload_type push_data,
   output logic                      in_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   output mstg_pkg::rsp_payload_type out_data
);
   import mstg_pkg::*;

   rsp_payload_type head_ff, head_in;
   rsp_payload_type tail_ff, tail_in;
   logic [1:0]      count_ff, count_in;
   logic            pop;

   assign pop       = out_valid && out_ready;
   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;

   // Push/pop bookkeeping
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

[design/melody_sequencer_tone_generator.sv]
// Melody sequencer tone generator. Takes one request per clock, back to back,
// while the response buffer has room, and returns one response per request;
// the response shows the state after that request and is registered in the
// response buffer, which holds two, so requests keep flowing while one response
// waits. A tick request is one reference clock of playback. Songs live
// in a SONG_COUNT x ENTRIES_PER_SONG x 16 bit synchronous store (hold in bits
// 15:8, code in 7:0); it is read on two ports every cycle, at entry 0 and at the
// entry after the position the request just produced, so a tick never waits on
// the store, and a write to an entry about to be read is forwarded. The store
// has no reset and no clearing pass: only written entries may be played.
// Control registers (index 0 delay_unit_ticks, index 1 gap_units) take a write
// every cycle and should only be written between requests.
// Depends on mstg_pkg, mstg_if, mstg_store, mstg_engine and mstg_rsp_buf.
`default_nettype none

module melody_sequencer_tone_generator #(
   parameter int SONG_COUNT       = 3,
   parameter int ENTRIES_PER_SONG = 256
) (
   input  logic       clock,
   input  logic       reset,
   mstg_req_if.sink   req_bus,
   mstg_rsp_if.source rsp_bus,
   mstg_csr_if.sink   csr_bus
);
   import mstg_pkg::*;

   cfg_type         cfg_ff;
   req_payload_type req;
   rsp_payload_type result;
   rsp_payload_type rsp_data;
   store_rd_type    store_rd;
   store_wr_type    store_wr;
   store_data_type  store_data;
   logic            req_fire;
   logic            buf_ready;

   assign req.req_type    = req_bus.req_type;
   assign req.song_number = req_bus.song_number;
   assign req.entry_index = req_bus.entry_index;
   assign req.note_code   = req_bus.note_code;
   assign req.hold_units  = req_bus.hold_units;

   assign req_bus.ready = buf_ready;
   assign req_fire      = req_bus.valid && buf_ready;

   // Control registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_unit_ticks <= DELAY_UNIT_TICKS_RESET;
         cfg_ff.gap_units        <= GAP_UNITS_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.wr_index)
            CSR_DELAY_UNIT_TICKS: cfg_ff.delay_unit_ticks <= csr_bus.wr_data;
            CSR_GAP_UNITS:        cfg_ff.gap_units        <= csr_bus.wr_data[7:0];
            default: ;
         endcase
      end
   end

   mstg_engine #(
      .SONG_COUNT       (SONG_COUNT),
      .ENTRIES_PER_SONG (ENTRIES_PER_SONG)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .req        (req),
      .cfg        (cfg_ff),
      .store_data (store_data),
      .store_rd   (store_rd),
      .store_wr   (store_wr),
      .result     (result)
   );

   mstg_store #(
      .SONG_COUNT       (SONG_COUNT),
      .ENTRIES_PER_SONG (ENTRIES_PER_SONG)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (store_data)
   );

   mstg_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (result),
      .in_ready  (buf_ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.speaker_level = rsp_data.speaker_level;
   assign rsp_bus.playing       = rsp_data.playing;
   assign rsp_bus.current_song  = rsp_data.current_song;
   assign rsp_bus.current_entry = rsp_data.current_entry;

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for the melody sequencer tone generator: drives requests, control register
// writes and response back-pressure, and checks each response against its own player.
// Depends on mstg_pkg, the mstg_if channel interfaces and melody_sequencer_tone_generator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mstg_pkg::*;

   localparam int SONGS            = 3;
   localparam int ENTRIES          = 256;
   localparam int RESET_CYCLES     = 9;
   localparam int CYCLE_LIMIT      = 3_000_000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int RANDOM_PER_PHASE = 80;
   localparam int MAX_REPORTS      = 40;

   localparam bit [7:0]  CSR_UNUSED = 8'd7;
   localparam bit [7:0]  CODE_REST  = 8'd255;
   localparam bit [25:0] DELAY_MAX  = 26'h3FF_FFFF;

   localparam bit [14:0] TONE_HALF [21] = '{
      15'd30534, 15'd27211, 15'd24242, 15'd22923, 15'd20408, 15'd18182, 15'd16194,
      15'd15289, 15'd13621, 15'd12135, 15'd11454, 15'd10204, 15'd9091,  15'd8099,
      15'd7645,  15'd6810,  15'd6067,  15'd5727,  15'd5102,  15'd4545,  15'd4050
   };

   // song 0: lowest and highest tone, short pause with max hold, rest,
   // out-of-table codes, and an end marker carrying a nonzero code
   localparam bit [7:0] DEMO_CODES [7] = '{8'd0, 8'd20, CODE_SHORT_PAUSE, CODE_REST,
                                           8'd21, 8'd253, CODE_REST};
   localparam bit [7:0] DEMO_HOLDS [7] = '{8'd1, 8'd1, 8'd255, 8'd2, 8'd1, 8'd1, 8'd0};

   // Player model plus the queue of responses still owed by the block
   class melody_scoreboard;
      bit [15:0]       song_mem [SONGS][ENTRIES];
      bit              written  [SONGS][ENTRIES];
      bit [25:0]       delay_cfg;
      bit [7:0]        gap_cfg;
      bit              play_en;
      bit [1:0]        song_sel;
      bit [7:0]        pos;
      phase_type       ph;
      bit [9:0]        units_left;
      bit [25:0]       unit_ticks;
      bit [14:0]       half_period;
      bit [14:0]       tone_cnt;
      bit              tone_on;
      bit              spk;
      rsp_payload_type expected_status [$];
      int              errors;

      function new();
         delay_cfg   = DELAY_UNIT_TICKS_RESET;
         gap_cfg     = GAP_UNITS_RESET;
         play_en     = 1'b0;
         song_sel    = 2'd0;
         half_period = '0;
         errors      = 0;
         silence();
      endfunction

      function void silence();
         ph         = PH_IDLE;
         pos        = '0;
         units_left = '0;
         unit_ticks = '0;
         tone_cnt   = '0;
         tone_on    = 1'b0;
         spk        = 1'b0;
      endfunction

      function void begin_gap();
         ph         = PH_GAP;
         units_left = 10'(gap_cfg);
         unit_ticks = '0;
         tone_on    = 1'b0;
         tone_cnt   = '0;
      endfunction

      function void load_entry();
         bit [15:0] word;
         bit [7:0]  code;
         bit [7:0]  hold;
         word = song_mem[song_sel][pos];
         code = word[7:0];
         hold = word[15:8];
         if (hold == 0) begin
            begin_gap();
            return;
         end
         ph         = PH_ENTRY;
         unit_ticks = '0;
         tone_cnt   = '0;
         if (code == CODE_SHORT_PAUSE) begin
            units_left = 10'd1;
            tone_on    = 1'b0;
         end else begin
            units_left = {hold, 2'b00};
            if (code <= CODE_LAST_TONE) begin
               tone_on     = 1'b1;
               half_period = TONE_HALF[code];
            end else begin
               tone_on = 1'b0;
            end
         end
      endfunction

      // one reference clock of playback
      function void tick();
         if (!play_en) return;
         if (ph == PH_IDLE) begin
            pos = '0;
            load_entry();
         end
         if (tone_on) begin
            if (tone_cnt >= half_period) begin
               spk      = ~spk;
               tone_cnt = '0;
            end else begin
               tone_cnt++;
            end
         end
         if (units_left != 0) begin
            unit_ticks = unit_ticks + 26'd1;
            if (unit_ticks >= delay_cfg) begin
               unit_ticks = '0;
               units_left--;
            end
         end
         if (units_left == 0) begin
            if (ph == PH_GAP) begin
               pos = '0;
               load_entry();
            end else if (int'(pos) + 1 >= ENTRIES) begin
               begin_gap();
            end else begin
               pos++;
               load_entry();
            end
         end
      endfunction

      function void write_register(bit [7:0] idx, bit [25:0] data);
         if (idx == CSR_DELAY_UNIT_TICKS) delay_cfg = data;
         else if (idx == CSR_GAP_UNITS) gap_cfg = data[7:0];
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type status;
         case (req_kind_type'(r.req_type))
            REQ_TICK: tick();
            REQ_TOGGLE_PLAY: begin
               play_en = ~play_en;
               silence();
            end
            REQ_NEXT_SONG: begin
               song_sel = (int'(song_sel) + 1 >= SONGS) ? 2'd0 : song_sel + 2'd1;
               silence();
            end
            REQ_WRITE_ENTRY: begin
               if (int'(r.song_number) < SONGS) begin
                  song_mem[r.song_number][r.entry_index] = {r.hold_units, r.note_code};
                  written[r.song_number][r.entry_index]  = 1'b1;
               end
            end
            default: ;
         endcase
         status.speaker_level = spk;
         status.playing       = play_en;
         status.current_song  = song_sel;
         status.current_entry = pos;
         expected_status.push_back(status);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            if (errors < MAX_REPORTS)
               $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_status.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("%0t: response with none expected, got %p", $time, got);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         compare_field("speaker_level", want.speaker_level, got.speaker_level);
         compare_field("playing", want.playing, got.playing);
         compare_field("current_song", want.current_song, got.current_song);
         compare_field("current_entry", want.current_entry, got.current_entry);
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      // A nonzero hold may only lead into an entry that is already written,
      // so playback never reaches an unwritten entry.
      function bit [7:0] chain_safe_hold(bit [1:0] s, bit [7:0] e, bit [7:0] h);
         if (int'(s) < SONGS && h != 0 && e != 8'd255 && !written[s][int'(e) + 1])
            return 8'd0;
         return h;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mstg_req_if req_bus ();
   mstg_rsp_if rsp_bus ();
   mstg_csr_if csr_bus ();

   melody_sequencer_tone_generator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   melody_scoreboard sb;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_off_pending   = 1'b0;
   int stall_left         = 0;
   int cycle_count        = 0;

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Response side: check accepted responses, then pick ready for the next cycle
   always @(posedge clock) begin : rsp_side
      rsp_payload_type seen;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.speaker_level = rsp_bus.speaker_level;
         seen.playing       = rsp_bus.playing;
         seen.current_song  = rsp_bus.current_song;
         seen.current_entry = rsp_bus.current_entry;
         sb.check_response(seen);
      end
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         stall_left       = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Offer one request, idling first at random; valid stays high afterwards
   task automatic send_request(input req_payload_type r);
      int idle;
      idle = 0;
      while ($urandom_range(99) < sender_idle_pct) idle++;
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= r.req_type;
      req_bus.song_number <= r.song_number;
      req_bus.entry_index <= r.entry_index;
      req_bus.note_code   <= r.note_code;
      req_bus.hold_units  <= r.hold_units;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_request(r);
   endtask

   // Non-write request; unused fields carry random bits
   task automatic issue(input req_kind_type k);
      req_payload_type r;
      r.req_type    = k;
      r.song_number = 2'($urandom);
      r.entry_index = 8'($urandom);
      r.note_code   = 8'($urandom);
      r.hold_units  = 8'($urandom);
      send_request(r);
   endtask

   task automatic write_entry(input bit [1:0] s, input bit [7:0] e, input bit [7:0] c,
                              input bit [7:0] h);
      req_payload_type r;
      r.req_type    = REQ_WRITE_ENTRY;
      r.song_number = s;
      r.entry_index = e;
      r.note_code   = c;
      r.hold_units  = h;
      send_request(r);
   endtask

   task automatic run_ticks(input int n);
      repeat (n) issue(REQ_TICK);
   endtask

   task automatic select_song(input bit [1:0] s);
      while (sb.song_sel != s) issue(REQ_NEXT_SONG);
   endtask

   task automatic set_playing(input bit enable);
      if (sb.play_en != enable) issue(REQ_TOGGLE_PLAY);
   endtask

   // Stop offering and wait until every owed response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Control register writes, back to back, only with the block drained
   task automatic configure(input bit [25:0] delay_ticks, input bit [25:0] gap_word,
                            input bit poke_unused);
      bit [7:0]  idx [3];
      bit [25:0] val [3];
      int        n;
      idx[0] = CSR_DELAY_UNIT_TICKS;
      val[0] = delay_ticks;
      idx[1] = CSR_GAP_UNITS;
      val[1] = gap_word;
      idx[2] = CSR_UNUSED;
      val[2] = 26'($urandom);
      n = poke_unused ? 3 : 2;
      wait_drained();
      for (int i = 0; i < n; i++) begin
         csr_bus.valid    <= 1'b1;
         csr_bus.wr_index <= idx[i];
         csr_bus.wr_data  <= val[i];
         @(posedge clock);
         while (csr_bus.ready !== 1'b1) @(posedge clock);
         sb.write_register(idx[i], val[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Random traffic, mostly ticks of an enabled player with live song edits
   task automatic random_phase(input int idle_pct, input int stall_pct,
                               input bit [25:0] delay_ticks, input bit [25:0] gap_word,
                               input int n);
      int       roll;
      bit [1:0] s;
      bit [7:0] e;
      bit [7:0] c;
      bit [7:0] h;
      configure(delay_ticks, gap_word, 1'b0);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         // long receiver hold-off while requests keep coming
         if (i == n / 3) hold_off_pending = 1'b1;
         // sender pause until the block has answered everything
         if (i == 2 * n / 3) wait_drained();
         roll = $urandom_range(99);
         if (!sb.play_en && roll < 40) begin
            issue(REQ_TOGGLE_PLAY);
         end else if (roll < 3) begin
            issue(REQ_TOGGLE_PLAY);
         end else if (roll < 6) begin
            issue(REQ_NEXT_SONG);
         end else if (roll < 18) begin
            s = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(SONGS - 1));
            e = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
            case ($urandom_range(3))
               0:       c = 8'($urandom_range(20));
               1:       c = CODE_SHORT_PAUSE;
               2:       c = CODE_REST;
               default: c = 8'($urandom_range(255));
            endcase
            if ($urandom_range(15) == 0) h = 8'd0;
            else if ($urandom_range(15) == 0) h = 8'd255;
            else h = 8'($urandom_range(3, 1));
            write_entry(s, e, c, sb.chain_safe_hold(s, e, h));
         end else begin
            issue(REQ_TICK);
         end
      end
   endtask

   initial begin
      sb = new();
      req_bus.valid       = 1'b0;
      req_bus.req_type    = '0;
      req_bus.song_number = '0;
      req_bus.entry_index = '0;
      req_bus.note_code   = '0;
      req_bus.hold_units  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.wr_index    = '0;
      csr_bus.wr_data     = '0;
      rsp_bus.ready       = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // shortest unit, zero gap; an unused register index is written too
      configure(26'd1, 26'd0, 1'b1);

      // song 0: directed codes; song 3 does not exist, so that write is dropped
      for (int i = 0; i < 7; i++) write_entry(2'd0, 8'(i), DEMO_CODES[i], DEMO_HOLDS[i]);
      write_entry(2'd3, 8'd255, CODE_REST, 8'd255);
      // song 1: short tune ending on an end marker
      write_entry(2'd1, 8'd0, 8'd10, 8'd1);
      write_entry(2'd1, 8'd1, CODE_SHORT_PAUSE, 8'd1);
      write_entry(2'd1, 8'd2, CODE_REST, 8'd0);
      // song 2: every entry filled, no end marker
      for (int e = 0; e < ENTRIES; e++) begin
         if (e % 16 == 5) write_entry(2'd2, 8'(e), 8'(e % 21), 8'd1);
         else if (e % 16 == 9) write_entry(2'd2, 8'(e), CODE_REST, 8'd1);
         else write_entry(2'd2, 8'(e), CODE_SHORT_PAUSE, 8'($urandom_range(255, 1)));
      end

      // play song 0 through its zero gap into a repeat, then switch songs mid-tune
      set_playing(1'b1);
      run_ticks(34);
      issue(REQ_NEXT_SONG);
      run_ticks(6);
      issue(REQ_TOGGLE_PLAY);
      run_ticks(2);
      issue(REQ_NEXT_SONG);
      issue(REQ_NEXT_SONG);
      set_playing(1'b1);
      run_ticks(3);

      // song without end marker: runs past the last entry into the gap
      select_song(2'd2);
      run_ticks(420);
      set_playing(1'b0);

      random_phase(0, 0, 26'd1, 26'd0, RANDOM_PER_PHASE);
      // zero delay_unit_ticks, longest gap, junk above the gap field
      random_phase(65, 0, 26'd0, (26'($urandom) & ~26'hFF) | 26'd255, RANDOM_PER_PHASE);
      random_phase(0, 65, 26'd2, 26'd3, RANDOM_PER_PHASE);
      random_phase(34, 34, DELAY_MAX, 26'd1, RANDOM_PER_PHASE);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
